/* hw/rtl/extent_map_allocator_unit_assert.svh */
// Assertion macros shared by the checker
`ifndef EXTENT_MAP_ALLOCATOR_UNIT_ASSERT_SVH
`define EXTENT_MAP_ALLOCATOR_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define EMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define EMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/ema_pkg.sv */
package ema_pkg;

	localparam int ENTRIES_DEF   = 64;
	localparam int PAGE_BITS_DEF = 20;

	localparam int NREGS    = 6;
	localparam int CFG_IW   = 3;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;

	localparam logic [OP_W-1:0] OP_ALLOC_LOW  = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC_TOP  = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC_AT   = 3'd2;
	localparam logic [OP_W-1:0] OP_RELEASE    = 3'd3;
	localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PLACE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADREL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

	localparam logic [CFG_IW-1:0] CFG_CORE_LOW_A  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_CORE_END_A  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_CORE_LOW_B  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_CORE_END_B  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SWAP_BASE   = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_SWAP_PAGES  = 3'd5;

endpackage

/* hw/rtl/extent_map_allocator_unit.sv */
// Extent map allocator: two address-ordered free-extent lists (memory, swap) sharing one
// pool of entries. An operation is taken when start is high and busy is low; its result
// word appears on result_area/status for exactly one cycle with done high, and cannot be
// held off. An operation walks the selected list one entry at a time (a fetch state, then
// a check state) through the one-read, one-write link/extent memories, then passes through
// its link-update states; unused operation codes and releases failing the range checks
// answer straight from idle without a walk. After reset a clearing pass over all ENTRIES+2
// nodes builds the pool chain, with busy high.
module extent_map_allocator_unit #(
	parameter int ENTRIES   = ema_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS = ema_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [ema_pkg::OP_W-1:0]      operation,
	input  logic                          map_select,
	input  logic [PAGE_BITS-1:0]          size,
	input  logic [PAGE_BITS-1:0]          area,
	output logic [PAGE_BITS-1:0]          result_area,
	output logic [ema_pkg::STATUS_W-1:0]  status,
	input  logic                          cfg_we,
	input  logic [ema_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [PAGE_BITS-1:0]          cfg_data
);

	localparam int PB    = PAGE_BITS;
	localparam int NODES = ENTRIES + 2;
	localparam int LW    = $clog2(ENTRIES + 3);
	localparam int IW    = $clog2(ENTRIES);
	localparam logic [LW-1:0] NIL   = LW'(ENTRIES + 2);
	localparam logic [LW-1:0] HEAD0 = LW'(ENTRIES);
	localparam logic [LW-1:0] LASTE = LW'(ENTRIES - 1);
	localparam logic [LW-1:0] LASTN = LW'(NODES - 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_FETCH, S_CHECK, S_TAKE, S_DROP1, S_DROP2, S_RELA, S_RELCHK,
		S_MERGEA, S_MERGEB, S_GROWB, S_NEW1, S_NEW2, S_NEW3
	} state_t;

	state_t state_q;

	logic [PB-1:0] cfg_q [ema_pkg::NREGS];

	// extent and link memories
	logic [PB-1:0] st_mem [ENTRIES];
	logic [PB-1:0] ln_mem [ENTRIES];
	logic [LW-1:0] nx_mem [NODES];
	logic [LW-1:0] pv_mem [NODES];

	logic [PB-1:0] rd_st, rd_ln;
	logic [LW-1:0] rd_nx, rd_pv;
	logic [LW-1:0] raddr;

	logic          st_we, ln_we, nx_we, pv_we;
	logic [IW-1:0] st_wa, ln_wa;
	logic [PB-1:0] st_wd, ln_wd;
	logic [LW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

	logic [ema_pkg::OP_W-1:0] op_q;
	logic          sel_q, first_q, bottom_q, mrgb_q;
	logic [PB-1:0] size_q, area_q, st_q, ln_q, aln_q, acc_q;
	logic [PB:0]   end_q;
	logic [LW-1:0] cur_q, nx_q, pv_q, pool_q, init_q, e_q;

	logic [LW-1:0] head;
	logic [PB:0]   in_end, swap_end, rd_sum, a_end;
	logic [PB-1:0] nln, sum_a;
	logic          range_bad, hit, a_has, b_has, merge_a, merge_b;

	assign head     = HEAD0 + LW'(sel_q);
	assign busy     = (state_q != S_IDLE);
	assign in_end   = {1'b0, area} + {1'b0, size};
	assign swap_end = {1'b0, cfg_q[ema_pkg::CFG_SWAP_BASE]}
	                + {1'b0, cfg_q[ema_pkg::CFG_SWAP_PAGES]};
	assign rd_sum   = {1'b0, rd_st} + {1'b0, rd_ln};
	assign a_end    = rd_sum;
	assign nln      = ln_q - size_q;
	assign sum_a    = aln_q + size_q;

	always_comb begin
		if (!map_select) begin
			range_bad = (area < cfg_q[ema_pkg::CFG_CORE_LOW_A]
			             || in_end > {1'b0, cfg_q[ema_pkg::CFG_CORE_END_A]})
			         && (area < cfg_q[ema_pkg::CFG_CORE_LOW_B]
			             || in_end > {1'b0, cfg_q[ema_pkg::CFG_CORE_END_B]});
		end else begin
			range_bad = area < cfg_q[ema_pkg::CFG_SWAP_BASE] || in_end > swap_end;
		end
		range_bad = range_bad || (size == '0) || in_end[PB];
	end

	always_comb begin
		case (op_q) inside
			ema_pkg::OP_ALLOC_LOW, ema_pkg::OP_ALLOC_TOP: hit = (rd_ln >= size_q);
			ema_pkg::OP_ALLOC_AT: hit = (rd_sum >= end_q) && (rd_st <= area_q);
			ema_pkg::OP_RELEASE:  hit = (rd_st >= area_q);
			default:              hit = 1'b0;
		endcase
	end

	assign a_has   = (pv_q != head);
	assign b_has   = (cur_q != head);
	assign merge_a = a_has && (a_end == {1'b0, area_q});
	assign merge_b = b_has && (end_q == {1'b0, st_q});

	always_comb begin
		unique case (state_q)
			S_RELA:  raddr = pv_q;
			S_NEW1:  raddr = pool_q;
			default: raddr = cur_q;
		endcase
	end

	// write port decode
	always_comb begin
		st_we = 1'b0; st_wa = cur_q[IW-1:0]; st_wd = st_q + size_q;
		ln_we = 1'b0; ln_wa = cur_q[IW-1:0]; ln_wd = nln;
		nx_we = 1'b0; nx_wa = cur_q; nx_wd = pool_q;
		pv_we = 1'b0; pv_wa = cur_q; pv_wd = pv_q;
		unique case (state_q)
			S_INIT: begin
				nx_we = 1'b1; nx_wa = init_q;
				pv_we = 1'b1; pv_wa = init_q;
				if (init_q < HEAD0) begin
					nx_wd = (init_q == LASTE) ? NIL : init_q + 1'b1;
					pv_wd = '0;
				end else begin
					nx_wd = init_q;
					pv_wd = init_q;
				end
			end
			S_CHECK: begin
				if (op_q == ema_pkg::OP_RELEASE_ALL && !first_q) begin
					nx_we = 1'b1;
					if (cur_q == head) begin
						nx_wd = head;
						pv_we = 1'b1; pv_wd = head;
					end
				end
			end
			S_TAKE: begin
				ln_we = 1'b1;
				st_we = bottom_q;
			end
			S_DROP1: begin
				nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
				pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
			end
			S_DROP2: nx_we = 1'b1;
			S_MERGEA: begin
				ln_we = 1'b1; ln_wa = pv_q[IW-1:0]; ln_wd = sum_a;
			end
			S_MERGEB: begin
				ln_we = 1'b1; ln_wa = pv_q[IW-1:0]; ln_wd = acc_q + ln_q;
			end
			S_GROWB: begin
				st_we = 1'b1; st_wd = st_q - size_q;
				ln_we = 1'b1; ln_wd = ln_q + size_q;
			end
			S_NEW2: begin
				st_we = 1'b1; st_wa = pool_q[IW-1:0]; st_wd = area_q;
				ln_we = 1'b1; ln_wa = pool_q[IW-1:0]; ln_wd = size_q;
				nx_we = 1'b1; nx_wa = pool_q; nx_wd = cur_q;
				pv_we = 1'b1; pv_wa = pool_q; pv_wd = pv_q;
			end
			S_NEW3: begin
				nx_we = 1'b1; nx_wa = pv_q; nx_wd = e_q;
				pv_we = 1'b1; pv_wa = cur_q; pv_wd = e_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		rd_st <= st_mem[raddr[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ln_we) ln_mem[ln_wa] <= ln_wd;
		rd_ln <= ln_mem[raddr[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		rd_nx <= nx_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		rd_pv <= pv_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ema_pkg::NREGS; i++) cfg_q[i] <= '0;
		end else if (cfg_we && cfg_index < ema_pkg::CFG_IW'(ema_pkg::NREGS)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			pool_q      <= '0;
			done        <= 1'b0;
			result_area <= '0;
			status      <= ema_pkg::ST_OK;
			op_q <= '0; sel_q <= 1'b0; size_q <= '0; area_q <= '0; end_q <= '0;
			cur_q <= '0; first_q <= 1'b0; st_q <= '0; ln_q <= '0; nx_q <= '0;
			pv_q <= '0; aln_q <= '0; acc_q <= '0; bottom_q <= 1'b0; mrgb_q <= 1'b0;
			e_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == LASTN) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q        <= operation;
						sel_q       <= map_select;
						size_q      <= size;
						area_q      <= area;
						end_q       <= in_end;
						cur_q       <= HEAD0 + LW'(map_select);
						first_q     <= 1'b1;
						result_area <= '0;
						status      <= ema_pkg::ST_OK;
						if (operation > ema_pkg::OP_RELEASE_ALL) begin
							done <= 1'b1;
						end else if (operation == ema_pkg::OP_RELEASE && range_bad) begin
							status <= ema_pkg::ST_BADREL;
							done   <= 1'b1;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: state_q <= S_CHECK;
				S_CHECK: begin
					st_q <= rd_st; ln_q <= rd_ln; nx_q <= rd_nx; pv_q <= rd_pv;
					if (first_q) begin
						first_q <= 1'b0;
						cur_q   <= (op_q == ema_pkg::OP_ALLOC_TOP) ? rd_pv : rd_nx;
						state_q <= S_FETCH;
					end else if (cur_q == head) begin
						// walked all the way round
						unique case (op_q)
							ema_pkg::OP_ALLOC_AT: begin
								status <= ema_pkg::ST_PLACE; done <= 1'b1; state_q <= S_IDLE;
							end
							ema_pkg::OP_RELEASE: state_q <= S_RELA;
							ema_pkg::OP_RELEASE_ALL: begin
								done <= 1'b1; state_q <= S_IDLE;
							end
							default: begin
								status <= ema_pkg::ST_NOFIT; done <= 1'b1; state_q <= S_IDLE;
							end
						endcase
					end else if (op_q == ema_pkg::OP_RELEASE_ALL) begin
						pool_q  <= cur_q;
						cur_q   <= rd_nx;
						state_q <= S_FETCH;
					end else if (hit) begin
						unique case (op_q)
							ema_pkg::OP_ALLOC_LOW: begin
								result_area <= rd_st; bottom_q <= 1'b1; state_q <= S_TAKE;
							end
							ema_pkg::OP_ALLOC_TOP: begin
								bottom_q <= 1'b0; state_q <= S_TAKE;
							end
							ema_pkg::OP_ALLOC_AT: begin
								if (rd_st == area_q) begin
									result_area <= area_q; bottom_q <= 1'b1; state_q <= S_TAKE;
								end else if (rd_sum != end_q) begin
									status <= ema_pkg::ST_PLACE; done <= 1'b1; state_q <= S_IDLE;
								end else begin
									result_area <= area_q; bottom_q <= 1'b0; state_q <= S_TAKE;
								end
							end
							default: state_q <= S_RELA;
						endcase
					end else begin
						cur_q   <= (op_q == ema_pkg::OP_ALLOC_TOP) ? rd_pv : rd_nx;
						state_q <= S_FETCH;
					end
				end
				S_TAKE: begin
					if (op_q == ema_pkg::OP_ALLOC_TOP) result_area <= st_q + nln;
					if (nln == '0) begin
						state_q <= S_DROP1;
					end else begin
						done <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_DROP1: state_q <= S_DROP2;
				S_DROP2: begin
					pool_q <= cur_q; done <= 1'b1; state_q <= S_IDLE;
				end
				S_RELA: state_q <= S_RELCHK;
				S_RELCHK: begin
					aln_q  <= rd_ln;
					mrgb_q <= merge_b;
					if ((a_has && a_end > {1'b0, area_q}) || (b_has && end_q > {1'b0, st_q})) begin
						status <= ema_pkg::ST_BADREL; done <= 1'b1; state_q <= S_IDLE;
					end else if (merge_a) begin
						state_q <= S_MERGEA;
					end else if (merge_b) begin
						state_q <= S_GROWB;
					end else if (pool_q == NIL) begin
						status <= ema_pkg::ST_OVERFLOW; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						state_q <= S_NEW1;
					end
				end
				S_MERGEA: begin
					acc_q <= sum_a;
					if (mrgb_q) begin
						state_q <= S_MERGEB;
					end else begin
						done <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_MERGEB: state_q <= S_DROP1;
				S_GROWB: begin
					done <= 1'b1; state_q <= S_IDLE;
				end
				S_NEW1: state_q <= S_NEW2;
				S_NEW2: begin
					e_q     <= pool_q;
					pool_q  <= rd_nx;
					state_q <= S_NEW3;
				end
				S_NEW3: begin
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/ema_checker.sv */
`include "extent_map_allocator_unit_assert.svh"

module ema_checker #(
	parameter int PAGE_BITS = ema_pkg::PAGE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [PAGE_BITS-1:0]          result_area,
	input logic [ema_pkg::STATUS_W-1:0]  status
);

	// a result word is only shown once the sequencer is back at rest
	`EMA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// an accepted word either answers at once or holds the block busy
	`EMA_ASSERT_NEXT(a_start_resp, clk, arst_n, start && !busy, done || busy)
	// only a granted allocation carries a page number
	`EMA_ASSERT_IMPL(a_fail_zero, clk, arst_n, done && status != ema_pkg::ST_OK,
		result_area == '0)
	`EMA_ASSERT_IMPL(a_status_code, clk, arst_n, done,
		status == ema_pkg::ST_OK || status == ema_pkg::ST_NOFIT ||
		status == ema_pkg::ST_PLACE || status == ema_pkg::ST_BADREL ||
		status == ema_pkg::ST_OVERFLOW)

endmodule

bind extent_map_allocator_unit ema_checker #(.PAGE_BITS(PAGE_BITS)) u_ema_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.result_area (result_area),
	.status      (status)
);
